// ----- rtl/deq_pkg.sv -----
// deq_pkg: shared constants, beat types and action codes of the statistics deque
package deq_pkg;

  // ring storage
  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int ACT_W  = 2;
  localparam int ITEM_W = 64;
  localparam int FILL_W = 11;
  localparam int STAT_W = 32;
  localparam int CFG_W  = 11;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ITEM_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic              ok;
    logic [ITEM_W-1:0] popped_value;
    logic [FILL_W-1:0] fill_level;
    logic [STAT_W-1:0] total_pushes;
    logic [STAT_W-1:0] total_push_failures;
    logic [STAT_W-1:0] total_pops;
    logic [FILL_W-1:0] peak_fill;
  } out_beat_t;

  // outcome of one accepted beat, as seen by the statistics counters
  typedef struct packed {
    logic             push_ok;
    logic             push_fail;
    logic             pop_ok;
    logic [CNT_W-1:0] fill;
  } stat_event_t;

  // counter values after the current beat
  typedef struct packed {
    logic [STAT_W-1:0] pushes;
    logic [STAT_W-1:0] push_failures;
    logic [STAT_W-1:0] pops;
    logic [CNT_W-1:0]  peak;
  } stat_t;

endpackage

// ----- rtl/deq_stats.sv -----
// deq_stats: usage counters of the deque (pushes, refused pushes, pops, peak fill)
module deq_stats (
  input  logic                clk,
  input  logic                rst,
  input  deq_pkg::stat_event_t ev,
  output deq_pkg::stat_t      stat_next
);
  import deq_pkg::*;

  logic [STAT_W-1:0] pushes;
  logic [STAT_W-1:0] push_failures;
  logic [STAT_W-1:0] pops;
  logic [CNT_W-1:0]  peak;

  // next counter values, wrapping at the counter width
  always_comb begin
    stat_next.pushes        = ev.push_ok   ? pushes + STAT_W'(1) : pushes;
    stat_next.push_failures = ev.push_fail ? push_failures + STAT_W'(1) : push_failures;
    stat_next.pops          = ev.pop_ok    ? pops + STAT_W'(1) : pops;
    stat_next.peak          = (ev.push_ok && (ev.fill > peak)) ? ev.fill : peak;
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pushes        <= '0;
      push_failures <= '0;
      pops          <= '0;
      peak          <= '0;
    end else begin
      pushes        <= stat_next.pushes;
      push_failures <= stat_next.push_failures;
      pops          <= stat_next.pops;
      peak          <= stat_next.peak;
    end
  end

endmodule

// ----- rtl/double_ended_queue_with_stats.sv -----
// double_ended_queue_with_stats: ring-buffer deque of 64-bit items with usage counters
//
// Each input beat pushes at the tail or head, or pops from the head or tail, of a
// ring held in one 1024 x 64 synchronous RAM. One beat is taken per clock unless
// in_stall holds it; its result passes through stage one (RAM read data) and then
// the output register, and a new beat may be taken before the last has left, since
// pointers and fill count update at acceptance. A refused push (full) or pop
// (empty) still returns a result with ok low and popped_value zero. Writing the
// capacity register empties the queue (statistics are kept); a capacity of zero
// behaves as one and values above the RAM depth saturate to it. The RAM has no
// reset and no clearing pass; only written slots are ever popped.
module double_ended_queue_with_stats (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  deq_pkg::in_beat_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output deq_pkg::out_beat_t      out_data,
  input  logic                    cfg_we,
  input  logic [deq_pkg::CFG_W-1:0] cfg_data
);
  import deq_pkg::*;

  // ring storage
  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_addr;

  // queue control state
  logic [CNT_W-1:0] cap;
  logic [PTR_W-1:0] cap_m1;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;

  // capacity sanitising for a register write
  logic [31:0]      cfg_ext;
  logic [CNT_W-1:0] cap_cfg;

  // per-beat decode
  logic             accept;
  logic [PTR_W-1:0] head_cur;
  logic [PTR_W-1:0] tail_cur;
  logic             is_push;
  logic             push_ok;
  logic             pop_ok;
  logic             ok;
  logic             is_pop_ok;

  stat_event_t      ev;
  stat_t            stat_next;

  // stage between acceptance and the RAM read data
  logic             s1_valid;
  logic             s1_ok;
  logic             s1_pop;
  logic [CNT_W-1:0] s1_fill;
  stat_t            s1_stat;
  logic             s1_move;

  deq_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .stat_next (stat_next)
  );

  // handshake
  assign s1_move  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  // capacity written: zero reads as one, above depth saturates
  always_comb begin
    cfg_ext = 32'(cfg_data);
    if (cfg_ext == 32'd0) begin
      cap_cfg = CNT_W'(1);
    end else if (cfg_ext > 32'(DEPTH)) begin
      cap_cfg = CNT_W'(DEPTH);
    end else begin
      cap_cfg = CNT_W'(cfg_ext);
    end
  end

  // pointer and count update for one beat
  always_comb begin
    head_cur   = ({1'b0, head} >= cap) ? '0 : head;
    tail_cur   = ({1'b0, tail} >= cap) ? '0 : tail;
    is_push    = (in_data.action == ACT_PUSH_TAIL) || (in_data.action == ACT_PUSH_HEAD);
    push_ok    = is_push && (count < cap);
    pop_ok     = !is_push && (count != '0);
    ok         = push_ok || pop_ok;
    is_pop_ok  = pop_ok;
    head_next  = head_cur;
    tail_next  = tail_cur;
    count_next = count;
    mem_addr   = tail_cur;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
      if (in_data.action == ACT_PUSH_TAIL) begin
        mem_addr  = tail_cur;
        tail_next = (tail_cur == cap_m1) ? '0 : tail_cur + PTR_W'(1);
      end else begin
        head_next = (head_cur == '0) ? cap_m1 : head_cur - PTR_W'(1);
        mem_addr  = head_next;
      end
      mem_we = accept;
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
      if (in_data.action == ACT_POP_HEAD) begin
        mem_addr  = head_cur;
        head_next = (head_cur == cap_m1) ? '0 : head_cur + PTR_W'(1);
      end else begin
        tail_next = (tail_cur == '0) ? cap_m1 : tail_cur - PTR_W'(1);
        mem_addr  = tail_next;
      end
      mem_re = accept;
    end
  end

  // statistics event, only on an accepted beat
  always_comb begin
    ev.push_ok   = accept && push_ok;
    ev.push_fail = accept && is_push && !push_ok;
    ev.pop_ok    = accept && pop_ok;
    ev.fill      = count_next;
  end

  // ring RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_data.item_value;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // queue control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= CNT_W'(DEPTH);
      cap_m1 <= PTR_W'(DEPTH - 1);
      head   <= '0;
      tail   <= '0;
      count  <= '0;
    end else if (cfg_we) begin
      cap    <= cap_cfg;
      cap_m1 <= PTR_W'(cap_cfg - CNT_W'(1));
      head   <= '0;
      tail   <= '0;
      count  <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // stage one: beat outcome waiting on the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok   <= ok;
      s1_pop  <= is_pop_ok;
      s1_fill <= count_next;
      s1_stat <= stat_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_data.ok                  <= s1_ok;
      out_data.popped_value        <= s1_pop ? rdata : '0;
      out_data.fill_level          <= FILL_W'(s1_fill);
      out_data.total_pushes        <= s1_stat.pushes;
      out_data.total_push_failures <= s1_stat.push_failures;
      out_data.total_pops          <= s1_stat.pops;
      out_data.peak_fill           <= FILL_W'(s1_stat.peak);
    end
  end

  // checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("fill count above capacity");

  a_ptrs_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} < cap) && ({1'b0, tail} < cap))
    else $error("ring pointer outside capacity");

  a_accept_to_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat lost before stage one");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |-> (out_data.popped_value == '0))
    else $error("refused beat carries a popped value");

endmodule

// ----- tb/deque_scoreboard.sv -----
// scoreboard package: predicts each deque outcome and checks the returned beats
`timescale 1ns / 100ps

package deque_tb_pkg;
  import deq_pkg::*;

  class deque_scoreboard;
    // predicted ring contents and pointers
    logic [ITEM_W-1:0] slots [DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       fill;
    int unsigned       peak;
    logic [CFG_W-1:0]  capacity;
    bit [STAT_W-1:0]   pushes;
    bit [STAT_W-1:0]   failures;
    bit [STAT_W-1:0]   pops;
    out_beat_t         pending_outcomes [$];
    int unsigned       errors;

    function new();
      head     = 0;
      tail     = 0;
      fill     = 0;
      peak     = 0;
      capacity = CFG_W'(DEPTH);
      pushes   = '0;
      failures = '0;
      pops     = '0;
      errors   = 0;
    endfunction

    // a capacity write empties the ring but keeps the counters
    function void set_capacity(logic [CFG_W-1:0] value);
      capacity = value;
      head     = 0;
      tail     = 0;
      fill     = 0;
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction

    // zero acts as one slot, anything above the ram depth saturates
    function int unsigned ring_slots();
      if (capacity == 0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return capacity;
    endfunction

    // work out the outcome of one accepted request beat
    function void note_request(in_beat_t req);
      out_beat_t   outcome;
      int unsigned ring;
      ring    = ring_slots();
      outcome = '0;
      if (req.action == ACT_PUSH_TAIL || req.action == ACT_PUSH_HEAD) begin
        if (fill < ring) begin
          if (req.action == ACT_PUSH_TAIL) begin
            slots[tail] = req.item_value;
            tail = (tail + 1 == ring) ? 0 : tail + 1;
          end else begin
            head = (head == 0) ? ring - 1 : head - 1;
            slots[head] = req.item_value;
          end
          pushes++;
          fill++;
          if (fill > peak) peak = fill;
          outcome.ok = 1'b1;
        end else begin
          failures++;
        end
      end else if (fill > 0) begin
        if (req.action == ACT_POP_HEAD) begin
          outcome.popped_value = slots[head];
          head = (head + 1 == ring) ? 0 : head + 1;
        end else begin
          tail = (tail == 0) ? ring - 1 : tail - 1;
          outcome.popped_value = slots[tail];
        end
        fill--;
        pops++;
        outcome.ok = 1'b1;
      end
      outcome.fill_level          = FILL_W'(fill);
      outcome.total_pushes        = pushes;
      outcome.total_push_failures = failures;
      outcome.total_pops          = pops;
      outcome.peak_fill           = FILL_W'(peak);
      pending_outcomes.push_back(outcome);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, logic [ITEM_W-1:0] got, logic [ITEM_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h, predicted %0h", name, got, want));
    endtask

    // compare a returned beat with the oldest prediction
    task check_outcome(out_beat_t got);
      out_beat_t want;
      if (pending_outcomes.size() == 0) begin
        report("result beat with no request outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        check_field("ok", ITEM_W'(got.ok), ITEM_W'(want.ok));
        check_field("popped_value", got.popped_value, want.popped_value);
        check_field("fill_level", ITEM_W'(got.fill_level), ITEM_W'(want.fill_level));
        check_field("total_pushes", ITEM_W'(got.total_pushes),
                    ITEM_W'(want.total_pushes));
        check_field("total_push_failures", ITEM_W'(got.total_push_failures),
                    ITEM_W'(want.total_push_failures));
        check_field("total_pops", ITEM_W'(got.total_pops), ITEM_W'(want.total_pops));
        check_field("peak_fill", ITEM_W'(got.peak_fill), ITEM_W'(want.peak_fill));
      end
    endtask
  endclass

endpackage

// ----- tb/testbench.sv -----
// testbench top: drives the statistics deque through directed and random traffic
`timescale 1ns / 100ps

module testbench;
  import deq_pkg::*;
  import deque_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               cycle_count;

  deque_scoreboard sb;

  double_ended_queue_with_stats DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[double_ended_queue_with_stats] ERROR");
      $finish;
    end
  end

  // result beats are checked as they are taken
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_outcome(out_data);
  end

  // receiver back-pressure: modes of random length
  initial begin
    int mode;
    int span;
    int period;
    int on_cycles;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      mode      = $urandom_range(3);
      span      = $urandom_range(20, 200);
      period    = $urandom_range(2, 12);
      on_cycles = $urandom_range(1, period - 1);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(99) < 30);
          2: out_stall <= ($urandom_range(99) < 70);
          default: out_stall <= ((c % period) < on_cycles);
        endcase
      end
    end
  end

  function automatic logic [ITEM_W-1:0] random_item();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_beat_t random_request(int push_pct);
    in_beat_t req;
    req.item_value = random_item();
    if ($urandom_range(99) < push_pct)
      req.action = $urandom_range(1) ? ACT_PUSH_HEAD : ACT_PUSH_TAIL;
    else
      req.action = $urandom_range(1) ? ACT_POP_HEAD : ACT_POP_TAIL;
    return req;
  endfunction

  // hold one request beat until it is taken
  task automatic send_request(in_beat_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic send_op(logic [ACT_W-1:0] action, logic [ITEM_W-1:0] value);
    in_beat_t req;
    req.action     = action;
    req.item_value = value;
    send_request(req);
  endtask

  task automatic idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_capacity(value);
  endtask

  // bursts of random requests; a negative bias picks a new one per burst
  task automatic run_random(int count, int fixed_pct);
    int sent;
    int burst;
    int push_pct;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      if (fixed_pct >= 0) push_pct = fixed_pct;
      else begin
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      for (int k = 0; k < burst && sent < count; k++) begin
        send_request(random_request(push_pct));
        sent++;
      end
      if ($urandom_range(9) == 0) drain();
      else idle(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  // stimulus
  initial begin
    sb       = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset capacity: refused pops, both ends, head wrapping below zero
    send_op(ACT_POP_HEAD, random_item());
    send_op(ACT_POP_TAIL, random_item());
    send_op(ACT_PUSH_TAIL, '0);
    send_op(ACT_PUSH_TAIL, '1);
    send_op(ACT_PUSH_HEAD, 64'hA5A5_A5A5_A5A5_A5A5);
    send_op(ACT_PUSH_HEAD, 64'h5A5A_5A5A_5A5A_5A5A);
    send_op(ACT_POP_TAIL, random_item());
    send_op(ACT_POP_HEAD, random_item());
    send_op(ACT_POP_HEAD, random_item());
    send_op(ACT_POP_TAIL, random_item());
    send_op(ACT_POP_HEAD, random_item());
    run_random(60, -1);

    // capacity zero acts as a single slot
    write_capacity('0);
    send_op(ACT_PUSH_HEAD, random_item());
    send_op(ACT_PUSH_TAIL, random_item());
    send_op(ACT_PUSH_HEAD, random_item());
    send_op(ACT_POP_TAIL, random_item());
    send_op(ACT_POP_TAIL, random_item());
    send_op(ACT_PUSH_TAIL, random_item());
    send_op(ACT_POP_HEAD, random_item());
    send_op(ACT_POP_HEAD, random_item());

    // small rings wrap and fill often
    write_capacity(CFG_W'(1));
    run_random(40, -1);
    write_capacity(CFG_W'(2));
    run_random(50, -1);
    write_capacity(CFG_W'(3));
    run_random(50, -1);
    write_capacity(CFG_W'($urandom_range(4, 12)));
    run_random(50, -1);
    write_capacity(CFG_W'($urandom_range(13, 200)));
    run_random(60, -1);
    write_capacity(CFG_W'($urandom_range(DEPTH + 1, 2046)));
    run_random(40, -1);

    // largest setting saturates; a push-only run then mixed traffic
    write_capacity('1);
    run_random(40, 100);
    run_random(20, -1);

    // wait for the tail of the results
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[double_ended_queue_with_stats] OK");
    end else begin
      $display("[double_ended_queue_with_stats] ERROR");
    end
    $finish;
  end

endmodule
